FILE: src/pidmm_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pidmm_pkg: shared definitions for the multimode PID controller
// Widths, register indexes, mode codes, reset values, the sequencer states and sat32.
// ----------------------------------------------------------------------------
package pidmm_pkg;

	localparam int FRAC_BITS      = 16;
	localparam int INTEGRAL_WIDTH = 48;
	localparam int DATA_W         = 32;
	localparam int GAIN_W         = 20;
	localparam int MODE_W         = 3;
	localparam int LIM_W          = 31;
	localparam int CFG_IDX_W      = 3;
	localparam int WEIGHT_W       = FRAC_BITS + 1;
	localparam int OPND_W         = INTEGRAL_WIDTH + 1;
	localparam int PROD_W         = OPND_W + 1 + GAIN_W;
	localparam int TERM_W         = PROD_W - FRAC_BITS;
	localparam int SUM_W          = 52;
	localparam int SAT_IN_W       = SUM_W + 1;
	localparam int CNT_W          = 5;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_MODE   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_P = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_I = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_D = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_UPPER  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_LOWER  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_SEP    = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_RAMP   = 3'd7;

	// mode codes
	localparam logic [MODE_W-1:0] MODE_POS    = 3'd0;
	localparam logic [MODE_W-1:0] MODE_SEP    = 3'd1;
	localparam logic [MODE_W-1:0] MODE_SEP_AW = 3'd2;
	localparam logic [MODE_W-1:0] MODE_VAR    = 3'd3;
	localparam logic [MODE_W-1:0] MODE_VAR_AW = 3'd4;
	localparam logic [MODE_W-1:0] MODE_INC    = 3'd5;

	// reset values
	localparam logic [MODE_W-1:0]        RST_MODE  = MODE_VAR_AW;
	localparam logic [GAIN_W-1:0]        RST_GAIN  = 20'd13107;
	localparam logic signed [DATA_W-1:0] RST_UPPER = 32'sd26214400;
	localparam logic signed [DATA_W-1:0] RST_LOWER = -32'sd13107200;
	localparam logic [LIM_W-1:0]         RST_SEP   = 31'd13107200;
	localparam logic [LIM_W-1:0]         RST_RAMP  = 31'd11796480;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ERR,
		ST_PREP,
		ST_DIV,
		ST_MLOAD,
		ST_MRUN,
		ST_MDONE,
		ST_FIN
	} pidmm_state_t;

	// saturate a wide signed value to 32 bits
	function automatic logic signed [DATA_W-1:0] sat32(input logic signed [SAT_IN_W-1:0] v);
		logic signed [SAT_IN_W-1:0] hi;
		logic signed [SAT_IN_W-1:0] lo;
		hi = SAT_IN_W'(32'sh7fffffff);
		lo = SAT_IN_W'(-33'sh080000000);
		if (v > hi) begin
			return 32'sh7fffffff;
		end else if (v < lo) begin
			return 32'sh80000000;
		end else begin
			return v[DATA_W-1:0];
		end
	endfunction

endpackage
`default_nettype wire

FILE: src/pid_controller_multimode_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pid_controller_multimode_core: multimode PID controller, Q16.16
// Bit-serial sequencer: one shared shift-add multiplier and a restoring divider.
// ----------------------------------------------------------------------------
// From accept to drive valid, incremental mode runs three products and the
// positional modes four, after a division when the integral weight ramp runs.
// Items are taken one at a time: a new one only once the sequencer is idle;
// every product takes the shared bit-serial multiplier, the weight the divider.
// A drive item still waiting holds the next item in the final state.
// Asynchronous active-low reset clears the loop state and loads register defaults.
module pid_controller_multimode_core (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_wr_en,
	input  logic [pidmm_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [pidmm_pkg::DATA_W-1:0]           cfg_data,
	input  logic                                   in_valid,
	output logic                                   in_ready,
	input  logic signed [pidmm_pkg::DATA_W-1:0]    setpoint,
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output logic signed [pidmm_pkg::DATA_W-1:0]    drive
);
	import pidmm_pkg::*;

	// configuration registers
	logic [MODE_W-1:0]        mode_q;
	logic [GAIN_W-1:0]        gain_p_q, gain_i_q, gain_d_q;
	logic signed [DATA_W-1:0] upper_q, lower_q;
	logic [LIM_W-1:0]         sep_q, ramp_q;

	// controller state
	logic signed [DATA_W-1:0]         pv_q, last_q, early_q;
	logic signed [INTEGRAL_WIDTH-1:0] acc_q;

	// working registers
	pidmm_state_t             state_q, state_d;
	logic signed [DATA_W-1:0] sp_q, err_q;
	logic [DATA_W-1:0]        mag_q;
	logic [MODE_W-1:0]        md_q;
	logic [WEIGHT_W-1:0]      weight_q;
	logic signed [OPND_W-1:0] ival_q;
	logic signed [SUM_W-1:0]  sum_q;
	logic [1:0]               op_q;
	logic [CNT_W-1:0]         cnt_q;
	logic [DATA_W:0]          rem_q;
	logic [LIM_W-1:0]         dvs_q;
	logic signed [OPND_W:0]   mhi_q;
	logic [GAIN_W-1:0]        mlo_q, mg_q;
	logic signed [OPND_W-1:0] mx_q;
	logic                     out_valid_q;
	logic signed [DATA_W-1:0] drive_q;

	// combinational helpers
	logic                     is_inc, last_op, fin_go, div_start;
	logic signed [DATA_W:0]   diff;
	logic signed [DATA_W-1:0] err_sat;
	logic                     sep_hit, ramp_hit, add_en;
	logic signed [DATA_W-1:0] div_v;
	logic signed [INTEGRAL_WIDTH:0] acc_sum;
	logic signed [INTEGRAL_WIDTH-1:0] acc_next;
	logic [GAIN_W-1:0]        ld_g;
	logic signed [OPND_W-1:0] ld_x;
	logic signed [OPND_W:0]   mstep;
	logic signed [TERM_W-1:0] term;
	logic signed [OPND_W-1:0] term_clamp;
	logic                     div_ge;
	logic signed [DATA_W-1:0] pv_new;

	assign is_inc    = (md_q == MODE_INC);
	assign last_op   = is_inc ? (op_q == 2'd2) : (op_q == 2'd3);
	assign fin_go    = !out_valid_q || out_ready;
	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign drive     = drive_q;

	// error and its saturation
	always_comb begin
		diff    = (DATA_W+1)'(sp_q) - (DATA_W+1)'(pv_q);
		err_sat = sat32(SAT_IN_W'(diff));
	end

	// separation, ramp, anti-windup and accumulation decisions
	always_comb begin
		sep_hit  = (md_q != MODE_POS) && (mag_q > {1'b0, sep_q});
		ramp_hit = ((md_q == MODE_VAR) || (md_q == MODE_VAR_AW)) && (mag_q >= {1'b0, ramp_q});
		div_v    = $signed({1'b0, sep_q}) - $signed({1'b0, ramp_q});
		div_start = !is_inc && !sep_hit && ramp_hit && (div_v > 0);
		add_en   = !sep_hit;
		if (add_en && ((md_q == MODE_SEP_AW) || (md_q == MODE_VAR_AW))) begin
			if (pv_q > upper_q) begin
				add_en = err_q < 0;
			end else if (pv_q < lower_q) begin
				add_en = err_q > 0;
			end
		end
		acc_sum = (INTEGRAL_WIDTH+1)'(acc_q) + (INTEGRAL_WIDTH+1)'(err_q);
		if (acc_sum[INTEGRAL_WIDTH] != acc_sum[INTEGRAL_WIDTH-1]) begin
			acc_next = acc_sum[INTEGRAL_WIDTH] ? {1'b1, {(INTEGRAL_WIDTH-1){1'b0}}}
				: {1'b0, {(INTEGRAL_WIDTH-1){1'b1}}};
		end else begin
			acc_next = acc_sum[INTEGRAL_WIDTH-1:0];
		end
	end

	// select multiplier operands for the current product
	always_comb begin
		ld_g = gain_p_q;
		ld_x = OPND_W'(err_q);
		if (is_inc) begin
			case (op_q)
				2'd0: begin
					ld_g = gain_p_q;
					ld_x = OPND_W'((DATA_W+1)'(err_q) - (DATA_W+1)'(early_q));
				end
				2'd1: begin
					ld_g = gain_i_q;
					ld_x = OPND_W'(err_q);
				end
				default: begin
					ld_g = gain_d_q;
					ld_x = OPND_W'((DATA_W+3)'(err_q) - ((DATA_W+3)'(early_q) <<< 1)
						+ (DATA_W+3)'(last_q));
				end
			endcase
		end else begin
			case (op_q)
				2'd0: begin
					ld_g = gain_p_q;
					ld_x = OPND_W'(err_q);
				end
				2'd1: begin
					ld_g = gain_i_q;
					ld_x = OPND_W'(acc_q);
				end
				2'd2: begin
					ld_g = GAIN_W'(weight_q);
					ld_x = ival_q;
				end
				default: begin
					ld_g = gain_d_q;
					ld_x = OPND_W'((DATA_W+1)'(err_q) - (DATA_W+1)'(last_q));
				end
			endcase
		end
	end

	// multiplier step, product scaling, divider step, final output
	always_comb begin
		mstep  = mhi_q + (mg_q[0] ? (OPND_W+1)'(mx_q) : '0);
		term   = $signed({mhi_q, mlo_q[GAIN_W-1:FRAC_BITS]});
		if (term > TERM_W'(64'sh0000800000000000)) begin
			term_clamp = OPND_W'(64'sh0000800000000000);
		end else if (term < -TERM_W'(64'sh0000800000000000)) begin
			term_clamp = -OPND_W'(64'sh0000800000000000);
		end else begin
			term_clamp = term[OPND_W-1:0];
		end
		div_ge = rem_q >= {2'b00, dvs_q};
		if (is_inc) begin
			pv_new = sat32(SAT_IN_W'(pv_q) + SAT_IN_W'(sum_q));
		end else begin
			pv_new = sat32(SAT_IN_W'(sum_q));
		end
	end

	// sequencer state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:  if (in_valid) state_d = ST_ERR;
			ST_ERR:   state_d = ST_PREP;
			ST_PREP:  state_d = div_start ? ST_DIV : ST_MLOAD;
			ST_DIV:   if (cnt_q == '0) state_d = ST_MLOAD;
			ST_MLOAD: state_d = ST_MRUN;
			ST_MRUN:  if (cnt_q == '0) state_d = ST_MDONE;
			ST_MDONE: state_d = last_op ? ST_FIN : ST_MLOAD;
			ST_FIN:   if (fin_go) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= RST_MODE;
			gain_p_q <= RST_GAIN;
			gain_i_q <= RST_GAIN;
			gain_d_q <= RST_GAIN;
			upper_q  <= RST_UPPER;
			lower_q  <= RST_LOWER;
			sep_q    <= RST_SEP;
			ramp_q   <= RST_RAMP;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_MODE:   mode_q   <= cfg_data[MODE_W-1:0];
				REG_GAIN_P: gain_p_q <= cfg_data[GAIN_W-1:0];
				REG_GAIN_I: gain_i_q <= cfg_data[GAIN_W-1:0];
				REG_GAIN_D: gain_d_q <= cfg_data[GAIN_W-1:0];
				REG_UPPER:  upper_q  <= $signed(cfg_data);
				REG_LOWER:  lower_q  <= $signed(cfg_data);
				REG_SEP:    sep_q    <= cfg_data[LIM_W-1:0];
				REG_RAMP:   ramp_q   <= cfg_data[LIM_W-1:0];
				default:    ;
			endcase
		end
	end

	// controller state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pv_q        <= '0;
			acc_q       <= '0;
			last_q      <= '0;
			early_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// accumulate the error unless incremental, separated or held by anti-windup
			if (state_q == ST_PREP && !is_inc && add_en) begin
				acc_q <= acc_next;
			end
			// commit the new output and shift the error history
			if (state_q == ST_FIN && fin_go) begin
				pv_q        <= pv_new;
				out_valid_q <= 1'b1;
				if (is_inc) begin
					last_q  <= early_q;
					early_q <= err_q;
				end else begin
					last_q <= err_q;
				end
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_FIN && fin_go) begin
			drive_q <= pv_new;
		end
	end

	// datapath working registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					sp_q <= setpoint;
				end
			end
			ST_ERR: begin
				err_q <= err_sat;
				mag_q <= err_sat[DATA_W-1] ? (~err_sat[DATA_W-1:0] + 1'b1) : err_sat[DATA_W-1:0];
				md_q  <= (mode_q > MODE_INC) ? MODE_POS : mode_q;
			end
			ST_PREP: begin
				sum_q <= '0;
				op_q  <= 2'd0;
				dvs_q <= div_v[LIM_W-1:0];
				rem_q <= (DATA_W+1)'(sep_q - mag_q[LIM_W-1:0]);
				cnt_q <= CNT_W'(WEIGHT_W - 1);
				if (sep_hit) begin
					weight_q <= '0;
				end else if (ramp_hit) begin
					weight_q <= '0;
				end else begin
					weight_q <= WEIGHT_W'(1) << FRAC_BITS;
				end
			end
			ST_DIV: begin
				// one quotient bit per cycle
				rem_q    <= (div_ge ? rem_q - {2'b00, dvs_q} : rem_q) << 1;
				weight_q <= {weight_q[WEIGHT_W-2:0], div_ge};
				cnt_q    <= cnt_q - 1'b1;
			end
			ST_MLOAD: begin
				mg_q  <= ld_g;
				mx_q  <= ld_x;
				mhi_q <= '0;
				mlo_q <= '0;
				cnt_q <= CNT_W'(GAIN_W - 1);
			end
			ST_MRUN: begin
				// add the multiplicand for one gain bit, then shift right
				mhi_q <= {mstep[OPND_W], mstep[OPND_W:1]};
				mlo_q <= {mstep[0], mlo_q[GAIN_W-1:1]};
				mg_q  <= mg_q >> 1;
				cnt_q <= cnt_q - 1'b1;
			end
			ST_MDONE: begin
				if (!is_inc && op_q == 2'd1) begin
					ival_q <= term_clamp;
				end else begin
					sum_q <= sum_q + term[SUM_W-1:0];
				end
				op_q <= op_q + 1'b1;
			end
			default: ;
		endcase
	end

endmodule
`default_nettype wire

FILE: src/pidmm_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pidmm_checker: port-level checks for the multimode PID controller
// Tracks items in flight and checks output hold and one-at-a-time intake.
// ----------------------------------------------------------------------------
module pidmm_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [31:0] drive
);
	logic [1:0] inflight_q;
	logic       in_acc, out_acc;

	assign in_acc  = in_valid && in_ready;
	assign out_acc = out_valid && out_ready;

	// count items taken but not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_q <= '0;
		end else if (in_acc && !out_acc) begin
			inflight_q <= inflight_q + 1'b1;
		end else if (out_acc && !in_acc) begin
			inflight_q <= inflight_q - 1'b1;
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("drive item dropped while stalled");

	a_drive_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(drive))
		else $error("drive changed while stalled");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> !in_ready)
		else $error("second item taken while one is in work");

	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> inflight_q != 2'd0)
		else $error("result shown with no item in flight");

	a_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		inflight_q != 2'd3)
		else $error("more than two items in flight");

endmodule

bind pid_controller_multimode_core pidmm_checker u_pidmm_checker (.*);
`default_nettype wire

FILE: sim/pid_controller_multimode_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pid_controller_multimode_core_tb: self-checking bench for the multimode PID
// Drives setpoints through every controller mode and several register
// settings, predicts each drive value in Q16.16 and checks it on the way out.
// ----------------------------------------------------------------------------
module pid_controller_multimode_core_tb;
	import pidmm_pkg::*;

	localparam int  CLK_HALF    = 2;
	localparam int  RESET_CYC   = 6;
	localparam int  SETTLE_CYC  = 150;
	localparam longint LIMIT_CYC = 1500000;
	localparam int  PHASES      = 12;
	localparam int  PHASE_ITEMS = 80;

	// controller model: registers, loop state and the queue of drive values
	class pid_scoreboard;
		logic [MODE_W-1:0] mode;
		longint gp, gi, gd, upper, lower, sep, ramp;
		longint pv, isum, last_e, prev_e;
		logic signed [DATA_W-1:0] drive_q[$];
		int errors;

		function new();
			mode   = RST_MODE;
			gp     = RST_GAIN;
			gi     = RST_GAIN;
			gd     = RST_GAIN;
			upper  = RST_UPPER;
			lower  = RST_LOWER;
			sep    = RST_SEP;
			ramp   = RST_RAMP;
			pv     = 0;
			isum   = 0;
			last_e = 0;
			prev_e = 0;
			errors = 0;
		endfunction

		function longint clip(longint v, longint lo, longint hi);
			return v < lo ? lo : (v > hi ? hi : v);
		endfunction

		function longint clip32(longint v);
			return clip(v, -64'sd2147483648, 64'sd2147483647);
		endfunction

		function longint scale(longint g, longint x);
			return (g * x) >>> FRAC_BITS;
		endfunction

		// gain_i times the accumulator, split in halves to stay in 64 bits
		function longint integral_product(longint acc);
			longint hi, lo, a, t;
			hi = acc >>> 32;
			lo = acc & 64'hffff_ffff;
			a  = clip(gi * hi, -(64'sd1 <<< (16 + FRAC_BITS)), 64'sd1 <<< (16 + FRAC_BITS));
			t  = a * (64'sd1 <<< (32 - FRAC_BITS)) + ((gi * lo) >>> FRAC_BITS);
			return clip(t, -(64'sd1 <<< 47), 64'sd1 <<< 47);
		endfunction

		function longint weigh(longint p, longint w);
			longint ph, pl;
			ph = p >>> FRAC_BITS;
			pl = p - (ph <<< FRAC_BITS);
			return ph * w + ((pl * w) >>> FRAC_BITS);
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] d);
			case (idx)
				REG_MODE:   mode  = d[MODE_W-1:0];
				REG_GAIN_P: gp    = longint'(d[GAIN_W-1:0]);
				REG_GAIN_I: gi    = longint'(d[GAIN_W-1:0]);
				REG_GAIN_D: gd    = longint'(d[GAIN_W-1:0]);
				REG_UPPER:  upper = longint'($signed(d));
				REG_LOWER:  lower = longint'($signed(d));
				REG_SEP:    sep   = longint'(d[LIM_W-1:0]);
				default:    ramp  = longint'(d[LIM_W-1:0]);
			endcase
		endfunction

		// advance the loop by one accepted setpoint
		function void note_setpoint(logic signed [DATA_W-1:0] sp);
			longint e, mag, w, dv, v, imax;
			logic [MODE_W-1:0] md;
			bit add;
			e    = clip32(longint'(sp) - pv);
			mag  = e < 0 ? -e : e;
			md   = (mode > MODE_INC) ? MODE_POS : mode;
			imax = (64'sd1 <<< (INTEGRAL_WIDTH - 1)) - 1;
			if (md == MODE_INC) begin
				v = scale(gp, e - prev_e) + scale(gi, e) + scale(gd, e - 2 * prev_e + last_e);
				pv = clip32(pv + v);
				last_e = prev_e;
				prev_e = e;
			end else begin
				w = 64'sd1 <<< FRAC_BITS;
				add = 1;
				if (md != MODE_POS && mag > sep) begin
					w = 0;
					add = 0;
				end else if ((md == MODE_VAR || md == MODE_VAR_AW) && mag >= ramp) begin
					dv = sep - ramp;
					w = dv > 0 ? ((sep - mag) <<< FRAC_BITS) / dv : 0;
				end
				// anti-windup: only let the integral move back toward the band
				if (add && (md == MODE_SEP_AW || md == MODE_VAR_AW)) begin
					if (pv > upper)
						add = e < 0;
					else if (pv < lower)
						add = e > 0;
				end
				if (add)
					isum = clip(isum + e, -imax - 1, imax);
				v = scale(gp, e) + weigh(integral_product(isum), w) + scale(gd, e - last_e);
				pv = clip32(v);
				last_e = e;
			end
			drive_q.push_back(DATA_W'(pv));
		endfunction

		function void check_drive(logic signed [DATA_W-1:0] act);
			logic signed [DATA_W-1:0] exp_v;
			if (drive_q.size() == 0) begin
				$display("%0t: drive %0d with no item outstanding", $time, act);
				errors++;
			end else begin
				exp_v = drive_q.pop_front();
				if (act !== exp_v) begin
					$display("%0t: drive mismatch expected %0d actual %0d", $time, exp_v, act);
					errors++;
				end
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic cfg_wr_en;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [DATA_W-1:0] cfg_data;
	logic in_valid;
	logic in_ready;
	logic signed [DATA_W-1:0] setpoint;
	logic out_valid;
	logic out_ready;
	logic signed [DATA_W-1:0] drive;

	pid_scoreboard sb;
	int send_idle_pct;
	int recv_stall_pct;
	longint cycles;

	pid_controller_multimode_core u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.setpoint  (setpoint),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.drive     (drive)
	);

	initial begin
		clk = 1'b0;
	end

	always begin
		#CLK_HALF clk = 1'b1;
		#CLK_HALF clk = 1'b0;
	end

	// random stall on the result side
	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// check every accepted drive item
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_drive(drive);
	end

	// give up on a hung run
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT_CYC) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] d);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= d;
		sb.write_reg(idx, d);
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	// hold one setpoint item until accepted; valid drops for random idle gaps between items
	task automatic send_setpoint(input logic signed [DATA_W-1:0] sp);
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		in_valid <= 1'b1;
		setpoint <= sp;
		do @(posedge clk); while (!in_ready);
		sb.note_setpoint(sp);
	endtask

	// drop valid and wait for every drive item, then let the sequencer settle
	task automatic drain();
		in_valid <= 1'b0;
		while (sb.drive_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYC) @(posedge clk);
	endtask

	// error aimed around the current output, near the interesting thresholds
	function automatic logic signed [DATA_W-1:0] pick_setpoint();
		longint off, span;
		case ($urandom_range(9))
			0: return $urandom;
			1: return $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
			default: begin
				span = (sb.sep > sb.ramp ? sb.sep : sb.ramp) + (longint'(40) <<< FRAC_BITS);
				if (span > 64'sd2147483647)
					span = 64'sd2147483647;
				off = longint'($urandom_range(32'(span)));
				if ($urandom_range(1))
					off = -off;
				return DATA_W'(sb.clip32(sb.pv + off));
			end
		endcase
	endfunction

	function automatic logic [DATA_W-1:0] pick_gain();
		case ($urandom_range(5))
			0: return 0;
			1: return 20'hfffff;
			2: return RST_GAIN;
			default: return $urandom_range(20'h20000);
		endcase
	endfunction

	initial begin
		logic signed [DATA_W-1:0] edge_vals[8];
		logic [DATA_W-1:0] sep_v, ramp_v;
		int k;
		sb = new();
		cycles = 0;
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		setpoint = '0;
		out_ready = 1'b0;
		send_idle_pct = 25;
		recv_stall_pct = 67;
		edge_vals = '{32'sh0, 32'sh7fffffff, 32'sh80000000, 32'sh1, -32'sh1,
			32'sh00c80000, -32'sh00b40000, 32'sh00c90000};
		repeat (RESET_CYC) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset settings, then each mode code including unused ones
		for (k = 0; k < 8; k++)
			send_setpoint(edge_vals[k]);
		drain();
		for (k = 0; k < 8; k++) begin
			// let the previous pair finish before the mode changes
			drain();
			write_reg(REG_MODE, DATA_W'(k));
			send_setpoint(edge_vals[(k * 3) % 8]);
			send_setpoint(edge_vals[(k * 3 + 1) % 8]);
		end
		drain();

		// random phases, each with its own register setting
		for (int ph = 0; ph < PHASES; ph++) begin
			send_idle_pct  = ph < 4 ? 25 : (ph < 8 ? 67 : 0);
			recv_stall_pct = ph < 4 ? 67 : (ph < 8 ? 25 : 0);
			case (ph % 4)
				0: begin
					sep_v  = $urandom_range(32'h7fffffff);
					ramp_v = $urandom_range(32'(sep_v));
				end
				1: begin
					sep_v  = 0;
					ramp_v = 0;
				end
				2: begin
					sep_v  = 32'h7fffffff;
					ramp_v = $urandom_range(32'h00ff0000);
				end
				default: begin
					// empty ramp: start at or above the separation threshold
					sep_v  = $urandom_range(32'h01000000);
					ramp_v = sep_v + $urandom_range(32'h00100000);
				end
			endcase
			write_reg(REG_MODE, DATA_W'(ph % 8));
			write_reg(REG_GAIN_P, pick_gain());
			write_reg(REG_GAIN_I, pick_gain());
			write_reg(REG_GAIN_D, pick_gain());
			write_reg(REG_UPPER, ph == 5 ? 32'h7fffffff : (ph == 6 ? 32'h80000000 : $urandom));
			write_reg(REG_LOWER, ph == 5 ? 32'h80000000 : (ph == 6 ? 32'h7fffffff :
				32'h80000000 | $urandom));
			write_reg(REG_SEP, sep_v);
			write_reg(REG_RAMP, ramp_v);
			for (k = 0; k < PHASE_ITEMS; k++)
				send_setpoint(pick_setpoint());
			drain();
		end

		if (sb.errors == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
